FILE: src/lpfp_pkg.sv
// Shared types and constants for the length-prefixed field parser.
`default_nettype none
package lpfp_pkg;

	localparam int VALUE_LENGTH_BITS_DEF = 32;

	localparam logic [7:0] TYPE_VALUE = 8'h21;  // '!'
	localparam logic [7:0] TYPE_ASK   = 8'h3F;  // '?'

	localparam logic [15:0] FIELD_MAX = 16'hFFFF;

	localparam logic [2:0] ROLE_HEADER = 3'd0;
	localparam logic [2:0] ROLE_TYPE   = 3'd1;
	localparam logic [2:0] ROLE_NLEN   = 3'd2;
	localparam logic [2:0] ROLE_NAME   = 3'd3;
	localparam logic [2:0] ROLE_VLEN   = 3'd4;
	localparam logic [2:0] ROLE_VALUE  = 3'd5;
	localparam logic [2:0] ROLE_IGNORE = 3'd6;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_TYPE  = 2'd1;
	localparam logic [1:0] ERR_TRUNC = 2'd2;

	localparam logic [1:0] VLEN_LAST = 2'd3;

	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_TYPE,
		PH_NLEN,
		PH_NAME,
		PH_VLEN,
		PH_VAL,
		PH_SKIP
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_packet;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  byte_role;
		logic [7:0]  byte_out;
		logic [15:0] field_number;
		logic        ask_flag;
		logic        field_complete;
		logic [1:0]  error_code;
		logic        packet_end;
	} out_item_t;

endpackage
`default_nettype wire

FILE: src/length_prefixed_field_parser_top.sv
// Length-prefixed field parser: labels each packet byte with its role.
//
// Usage: packet bytes arrive one per request on the item channel
// (item_valid / item_stall / item), with end_of_packet set on the final
// byte. Every byte yields exactly one result on the res channel
// (res_valid / res_stall / res) carrying its role, the byte itself, the
// field index, ask flag, field-complete mark, error code and packet end.
// Path: a byte accepted into the input register moves on to the result
// register once the result register can take it.
// Throughput: one byte per cycle while the receiver does not stall, set
// by the single parse-state update between the two registers; no bubbles
// between packets.
// Reset (arst_n low) empties both registers and puts the parser at the
// first header byte with field count zero. The final byte of a packet
// also returns the parser to that state for the next packet.
// When the receiver stalls, the result holds and the input register
// fills; item_stall rises once both registers hold a request.
`default_nettype none
module length_prefixed_field_parser_top
	import lpfp_pkg::*;
#(
	parameter int VALUE_LENGTH_BITS = VALUE_LENGTH_BITS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      item_valid,
	output      logic      item_stall,
	input  wire in_item_t  item,
	output      logic      res_valid,
	input  wire logic      res_stall,
	output      out_item_t res
);

	localparam int LW = VALUE_LENGTH_BITS;

	// pipeline registers
	in_item_t  item_s1;
	logic      vld_s1;
	out_item_t res_s2;
	logic      vld_s2;

	// parse state
	phase_t         phase_q, phase_d;
	logic [LW-1:0]  rem_q, rem_d;
	logic [1:0]     lcnt_q, lcnt_d;
	logic [15:0]    fcnt_q, fcnt_d;
	logic           ask_q, ask_d;

	logic           s2_ready;
	logic           adv;
	logic [7:0]     b;
	logic           last;
	logic           fin;
	logic           bad_type;
	logic [LW-1:0]  rem_dec;
	logic [LW+7:0]  acc_w;
	logic [LW-1:0]  acc_sat;
	out_item_t      res_d;

	assign s2_ready   = !vld_s2 || !res_stall;
	assign adv        = vld_s1 && s2_ready;
	assign item_stall = vld_s1 && !s2_ready;
	assign res_valid  = vld_s2;
	assign res        = res_s2;

	assign b    = item_s1.data_byte;
	assign last = item_s1.end_of_packet;

	assign rem_dec = (rem_q == '0) ? '0 : rem_q - LW'(1);
	assign acc_w   = {rem_q, b};
	assign acc_sat = (|acc_w[LW+7:LW]) ? '1 : acc_w[LW-1:0];

	// next state
	always_comb begin
		phase_d  = phase_q;
		rem_d    = rem_q;
		lcnt_d   = lcnt_q;
		ask_d    = ask_q;
		fcnt_d   = fcnt_q;
		fin      = 1'b0;
		bad_type = 1'b0;
		case (phase_q)
			PH_HDR0: phase_d = PH_HDR1;
			PH_HDR1: phase_d = PH_TYPE;
			PH_TYPE: begin
				if (b == TYPE_VALUE || b == TYPE_ASK) begin
					ask_d   = (b == TYPE_ASK);
					phase_d = PH_NLEN;
				end else begin
					bad_type = 1'b1;
					phase_d  = PH_SKIP;
				end
			end
			PH_NLEN: begin
				rem_d = LW'(b);
				if (b != 8'd0) begin
					phase_d = PH_NAME;
				end else if (ask_q) begin
					fin = 1'b1;
				end else begin
					phase_d = PH_VLEN;
					lcnt_d  = 2'd0;
				end
			end
			PH_NAME: begin
				rem_d = rem_dec;
				if (rem_dec == '0) begin
					if (ask_q) begin
						fin = 1'b1;
					end else begin
						phase_d = PH_VLEN;
						lcnt_d  = 2'd0;
					end
				end
			end
			PH_VLEN: begin
				rem_d = acc_sat;
				if (lcnt_q == VLEN_LAST) begin
					lcnt_d = 2'd0;
					if (acc_sat == '0)
						fin = 1'b1;
					else
						phase_d = PH_VAL;
				end else begin
					lcnt_d = lcnt_q + 2'd1;
				end
			end
			PH_VAL: begin
				rem_d = rem_dec;
				if (rem_dec == '0)
					fin = 1'b1;
			end
			default: ;
		endcase
		if (fin) begin
			phase_d = PH_TYPE;
			if (fcnt_q != FIELD_MAX)
				fcnt_d = fcnt_q + 16'd1;
		end
	end

	// result fields
	always_comb begin
		res_d.byte_out       = b;
		res_d.field_number   = fcnt_q;
		res_d.field_complete = fin;
		res_d.packet_end     = last;
		res_d.ask_flag       = ask_q;
		case (phase_q)
			PH_HDR0, PH_HDR1: begin
				res_d.byte_role = ROLE_HEADER;
				res_d.ask_flag  = 1'b0;
			end
			PH_TYPE: begin
				res_d.byte_role = ROLE_TYPE;
				res_d.ask_flag  = !bad_type && ask_d;
			end
			PH_NLEN: res_d.byte_role = ROLE_NLEN;
			PH_NAME: res_d.byte_role = ROLE_NAME;
			PH_VLEN: res_d.byte_role = ROLE_VLEN;
			PH_VAL:  res_d.byte_role = ROLE_VALUE;
			default: begin
				res_d.byte_role = ROLE_IGNORE;
				res_d.ask_flag  = 1'b0;
			end
		endcase
		if (bad_type)
			res_d.error_code = ERR_TYPE;
		else if (last && phase_d != PH_TYPE && phase_d != PH_SKIP)
			res_d.error_code = ERR_TRUNC;
		else
			res_d.error_code = ERR_NONE;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!item_stall) begin
			vld_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid)
			item_s1 <= item;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s2_ready) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= res_d;
	end

	// parse state; the last byte of a packet returns everything to reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			rem_q   <= '0;
			lcnt_q  <= 2'd0;
			fcnt_q  <= 16'd0;
			ask_q   <= 1'b0;
		end else if (adv) begin
			if (last) begin
				phase_q <= PH_HDR0;
				rem_q   <= '0;
				lcnt_q  <= 2'd0;
				fcnt_q  <= 16'd0;
				ask_q   <= 1'b0;
			end else begin
				phase_q <= phase_d;
				rem_q   <= rem_d;
				lcnt_q  <= lcnt_d;
				fcnt_q  <= fcnt_d;
				ask_q   <= ask_d;
			end
		end
	end

endmodule
`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the length-prefixed field parser top level.
`timescale 1ns / 1ps
module testbench
	import lpfp_pkg::*;
();

	localparam int IDLE_PCT = 34;
	localparam int QUIET_SPAN = 300;
	localparam int RANDOM_ITEMS = 1000;
	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_LIMIT = 2000;
	localparam int VLEN_BITS = VALUE_LENGTH_BITS_DEF;
	localparam logic [39:0] LEN_CAP = (40'd1 << VLEN_BITS) - 40'd1;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      item_valid;
	logic      item_stall;
	in_item_t  item;
	logic      res_valid;
	logic      res_stall;
	out_item_t res;

	length_prefixed_field_parser_top #(
		.VALUE_LENGTH_BITS(VLEN_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	in_item_t  packet_bytes[$];
	out_item_t labels_due[$];
	out_item_t want;

	// parser state mirror
	phase_t      phase;
	logic [31:0] span_left;
	logic [1:0]  len_bytes_seen;
	logic [15:0] field_idx;
	logic        field_is_ask;

	int  mismatches = 0;
	int  n_accepted = 0;
	int  n_results = 0;
	int  quiet_from = 32'h7fff_ffff;
	int  idle_cycles = 0;
	logic quiet = 1'b0;

	function automatic void clear_parse_state();
		phase = PH_HDR0;
		span_left = '0;
		len_bytes_seen = '0;
		field_idx = '0;
		field_is_ask = 1'b0;
	endfunction

	function automatic out_item_t label_byte(input in_item_t it);
		out_item_t r;
		logic [39:0] acc;
		logic field_done;
		r = '0;
		r.byte_role = ROLE_IGNORE;
		r.byte_out = it.data_byte;
		r.field_number = field_idx;
		r.packet_end = it.end_of_packet;
		field_done = 1'b0;
		case (phase)
		PH_HDR0: begin
			r.byte_role = ROLE_HEADER;
			phase = PH_HDR1;
		end
		PH_HDR1: begin
			r.byte_role = ROLE_HEADER;
			phase = PH_TYPE;
		end
		PH_TYPE: begin
			r.byte_role = ROLE_TYPE;
			if (it.data_byte == TYPE_VALUE || it.data_byte == TYPE_ASK) begin
				field_is_ask = (it.data_byte == TYPE_ASK);
				r.ask_flag = field_is_ask;
				phase = PH_NLEN;
			end else begin
				r.error_code = ERR_TYPE;
				phase = PH_SKIP;
			end
		end
		PH_NLEN: begin
			r.byte_role = ROLE_NLEN;
			r.ask_flag = field_is_ask;
			span_left = {24'd0, it.data_byte};
			if (it.data_byte != 8'd0) begin
				phase = PH_NAME;
			end else if (field_is_ask) begin
				field_done = 1'b1;
			end else begin
				phase = PH_VLEN;
				len_bytes_seen = '0;
				span_left = '0;
			end
		end
		PH_NAME: begin
			r.byte_role = ROLE_NAME;
			r.ask_flag = field_is_ask;
			if (span_left != 0)
				span_left = span_left - 1;
			if (span_left == 0) begin
				if (field_is_ask) begin
					field_done = 1'b1;
				end else begin
					phase = PH_VLEN;
					len_bytes_seen = '0;
					span_left = '0;
				end
			end
		end
		PH_VLEN: begin
			r.byte_role = ROLE_VLEN;
			r.ask_flag = field_is_ask;
			acc = {span_left, it.data_byte};
			if (acc > LEN_CAP)
				acc = LEN_CAP;
			span_left = acc[31:0];
			if (len_bytes_seen == VLEN_LAST) begin
				len_bytes_seen = '0;
				if (span_left == 0)
					field_done = 1'b1;
				else
					phase = PH_VAL;
			end else begin
				len_bytes_seen = len_bytes_seen + 2'd1;
			end
		end
		PH_VAL: begin
			r.byte_role = ROLE_VALUE;
			r.ask_flag = field_is_ask;
			if (span_left != 0)
				span_left = span_left - 1;
			if (span_left == 0)
				field_done = 1'b1;
		end
		default: ;
		endcase
		if (field_done) begin
			r.field_complete = 1'b1;
			if (field_idx != FIELD_MAX)
				field_idx = field_idx + 16'd1;
			phase = PH_TYPE;
		end
		// unfinished header or field at the last byte
		if (it.end_of_packet && r.error_code == ERR_NONE && phase != PH_TYPE
				&& phase != PH_SKIP)
			r.error_code = ERR_TRUNC;
		if (it.end_of_packet)
			clear_parse_state();
		return r;
	endfunction

	task automatic note_failure(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch: %s", msg);
	endtask

	task automatic check_field(input string fname, input logic [31:0] exp_val,
			input logic [31:0] got_val);
		if (exp_val !== got_val)
			note_failure($sformatf("%s of result %0d: expected %0h, got %0h",
				fname, n_results, exp_val, got_val));
	endtask

	task automatic add_byte(input logic [7:0] b, input logic last);
		in_item_t it;
		it.data_byte = b;
		it.end_of_packet = last;
		packet_bytes.push_back(it);
	endtask

	task automatic add_bytes(input logic [7:0] bytes[$]);
		foreach (bytes[i])
			add_byte(bytes[i], i == bytes.size() - 1);
	endtask

	// Well-formed packet with random content, optionally ending on a bad type
	// byte and its ignored tail, optionally cut off at a random point.
	task automatic add_packet(input bit bad_type, input bit cut_short, output int counted);
		logic [7:0] pkt[$];
		logic [7:0] type_byte;
		int n_fields;
		int name_len;
		int value_len;
		int keep;
		bit is_ask;
		pkt.push_back(8'($urandom));
		pkt.push_back(8'($urandom));
		n_fields = $urandom_range(0, 4);
		for (int f = 0; f < n_fields; f++) begin
			is_ask = ($urandom_range(0, 2) == 0);
			name_len = ($urandom_range(0, 39) == 0) ? $urandom_range(0, 255)
				: $urandom_range(0, 6);
			value_len = ($urandom_range(0, 39) == 0) ? $urandom_range(0, 300)
				: $urandom_range(0, 6);
			pkt.push_back(is_ask ? TYPE_ASK : TYPE_VALUE);
			pkt.push_back(8'(name_len));
			repeat (name_len) pkt.push_back(8'($urandom));
			if (!is_ask) begin
				for (int s = 24; s >= 0; s -= 8)
					pkt.push_back(8'(value_len >> s));
				repeat (value_len) pkt.push_back(8'($urandom));
			end
		end
		counted = pkt.size();
		if (bad_type) begin
			do
				type_byte = 8'($urandom);
			while (type_byte == TYPE_VALUE || type_byte == TYPE_ASK);
			pkt.push_back(type_byte);
			counted++;
			repeat ($urandom_range(0, 4)) pkt.push_back(8'($urandom));
		end
		if (cut_short) begin
			keep = $urandom_range(1, pkt.size() - 1);
			while (pkt.size() > keep)
				void'(pkt.pop_back());
			if (counted > keep)
				counted = keep;
		end
		add_bytes(pkt);
	endtask

	// Driver: next request goes out once the current one is taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				labels_due.push_back(label_byte(item));
				n_accepted++;
			end
			if (!item_valid || !item_stall) begin
				if (packet_bytes.size() > 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
					item_valid <= 1'b1;
					item <= packet_bytes.pop_front();
				end else begin
					item_valid <= 1'b0;
				end
			end
			quiet <= (n_accepted >= quiet_from && n_accepted < quiet_from + QUIET_SPAN);
		end
	end

	// Monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				n_results++;
				if (labels_due.size() == 0) begin
					note_failure($sformatf("result %0d arrived with none pending: %p",
						n_results, res));
				end else begin
					want = labels_due.pop_front();
					check_field("byte_role", 32'(want.byte_role), 32'(res.byte_role));
					check_field("byte_out", 32'(want.byte_out), 32'(res.byte_out));
					check_field("field_number", 32'(want.field_number),
						32'(res.field_number));
					check_field("ask_flag", 32'(want.ask_flag), 32'(res.ask_flag));
					check_field("field_complete", 32'(want.field_complete),
						32'(res.field_complete));
					check_field("error_code", 32'(want.error_code), 32'(res.error_code));
					check_field("packet_end", 32'(want.packet_end), 32'(res.packet_end));
				end
			end
			res_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Watchdog on cycles with no progress on either channel
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (res_valid && !res_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int random_items;
		int counted;
		int pick;
		int noise_len;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		res_stall = 1'b0;
		clear_parse_state();

		// header cut after one byte
		add_bytes('{8'hFF});
		// empty ask field, full name/value field, empty-name field with an
		// all-ones value length whose value is cut short
		add_bytes('{8'h34, 8'h12, TYPE_ASK, 8'h00,
			TYPE_VALUE, 8'h01, 8'h61, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'hFF,
			TYPE_VALUE, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hAA});
		// bad type byte, then a valid-looking byte that must be ignored
		add_bytes('{8'h00, 8'h00, 8'h00, TYPE_VALUE});

		quiet_from = packet_bytes.size();
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 95) begin
				add_packet(pick >= 85, pick >= 70 && pick < 85, counted);
			end else begin
				noise_len = $urandom_range(1, 12);
				for (int i = 0; i < noise_len; i++)
					add_byte(8'($urandom), i == noise_len - 1);
				counted = (noise_len < 3) ? noise_len : 3;
			end
			random_items += counted;
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (packet_bytes.size() != 0 || item_valid)
			@(posedge clk);
		while (labels_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
